[rtl/dttp_pkg.sv]
// Shared types and constants of the device tree token parser.
// Depends on nothing; imported by the top, front and back modules and by the bench.
`default_nettype none

package dttp_pkg;

    localparam int MAX_NEST_DEFAULT = 32;
    localparam int MID_DEPTH        = 4;
    localparam int RES_DEPTH        = 2;

    localparam logic [31:0] BLOB_MAGIC     = 32'hd00dfeed;
    localparam logic [31:0] BLOB_VERSION   = 32'd17;
    localparam logic [31:0] POS_MAGIC      = 32'd0;
    localparam logic [31:0] POS_OFF_STRUCT = 32'd8;
    localparam logic [31:0] POS_LAST_COMP  = 32'd24;
    localparam logic [31:0] POS_SIZE_STRUCT = 32'd36;
    localparam logic [31:0] MIN_STRUCT_OFF = 32'd40;

    localparam logic [31:0] TOKEN_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOKEN_END_NODE   = 32'd2;
    localparam logic [31:0] TOKEN_PROP       = 32'd3;
    localparam logic [31:0] TOKEN_NOP        = 32'd4;
    localparam logic [31:0] TOKEN_END        = 32'd9;

    localparam logic [1:0] PROP_HDR_WORDS = 2'd2;

    typedef enum logic [2:0] {
        TOK_BEGIN,
        TOK_END_NODE,
        TOK_PROP,
        TOK_NOP,
        TOK_FINISH,
        TOK_BAD
    } tok_kind_t;

    typedef enum logic [2:0] {
        EV_NODE   = 3'd0,
        EV_DONE   = 3'd1,
        EV_BADHDR = 3'd2,
        EV_BADTOK = 3'd3,
        EV_DEEP   = 3'd4,
        EV_UNDER  = 3'd5,
        EV_TRUNC  = 3'd6
    } ev_kind_t;

    typedef struct packed {
        logic        start;
        logic [31:0] pos;
        logic [31:0] word;
        logic [32:0] next4;
        logic [33:0] next12;
        logic        zero_byte;
        logic [29:0] pad_words;
        tok_kind_t   tok;
    } word_rec_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [4:0]  depth;
        logic [31:0] name_offset;
        logic [31:0] props_offset;
    } result_t;

endpackage

`default_nettype wire

[rtl/device_tree_token_parser_top.sv]
// Top level of the device tree token parser: front, middle queue, back, result queue.
// Depends on dttp_pkg, dttp_front, dttp_fifo and dttp_back.
//
// Input channel: blob words in order from byte offset 0, start_of_blob marking
// the first word of a blob. A word transfers at a clock edge with push high
// and full low. Result channel: while empty is low the oldest event sits on
// event_kind, node_depth, name_offset and props_offset; it transfers at an
// edge with pop high.
// One event per node, then one done or error event; after that the parser
// ignores words until the next start_of_blob.
// Throughput: one word per cycle while the result queue has room; the back end's token
// state machine takes a word on each pop. A word waits in the middle queue and
// its event in the registered result queue before the event can transfer out.
// When the receiver stalls, the result queue fills, the back end holds, and
// the four-entry middle queue absorbs words before full rises.
// Reset clears both queues, the byte position and the parser state; the first
// word after reset is taken as byte offset 0.
`default_nettype none

module device_tree_token_parser_top
    import dttp_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        start_of_blob,
    input  wire logic [31:0] blob_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       event_kind,
    output logic [4:0]       node_depth,
    output logic [31:0]      name_offset,
    output logic [31:0]      props_offset
);

    word_rec_t front_rec;
    word_rec_t mid_rec;
    logic      front_push;
    logic      mid_full;
    logic      mid_empty;
    logic      mid_pop;
    result_t   back_res;
    result_t   out_res;
    logic      res_push;
    logic      res_full;

    dttp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .start_of_blob (start_of_blob),
        .blob_word     (blob_word),
        .rec           (front_rec),
        .rec_push      (front_push),
        .rec_full      (mid_full)
    );

    dttp_fifo #(
        .WIDTH ($bits(word_rec_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_rec),
        .full    (mid_full),
        .rd_en   (mid_pop),
        .rd_data (mid_rec),
        .empty   (mid_empty)
    );

    dttp_back #(
        .MAX_NEST (MAX_NEST)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (mid_rec),
        .rec_empty (mid_empty),
        .rec_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    dttp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (out_res),
        .empty   (empty)
    );

    assign event_kind   = out_res.kind;
    assign node_depth   = out_res.depth;
    assign name_offset  = out_res.name_offset;
    assign props_offset = out_res.props_offset;

endmodule

`default_nettype wire

[rtl/dttp_fifo.sv]
// Small register queue with count-based full and empty flags.
// Depends on nothing; used between front and back and on the result side.
`default_nettype none

module dttp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/dttp_front.sv]
// Front end: takes blob words, tracks byte position, classifies each word.
// Depends on dttp_pkg; feeds the middle queue in front of dttp_back.
`default_nettype none

module dttp_front
    import dttp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        start_of_blob,
    input  wire logic [31:0] blob_word,
    output word_rec_t        rec,
    output logic             rec_push,
    input  wire logic        rec_full
);

    logic [31:0] pos_reg;
    logic [31:0] pos_next;
    logic [31:0] pos_cur;
    logic [32:0] plus3;

    function automatic tok_kind_t classify(input logic [31:0] w);
        tok_kind_t k;
        case (w)
            TOKEN_BEGIN_NODE: k = TOK_BEGIN;
            TOKEN_END_NODE:   k = TOK_END_NODE;
            TOKEN_PROP:       k = TOK_PROP;
            TOKEN_NOP:        k = TOK_NOP;
            TOKEN_END:        k = TOK_FINISH;
            default:          k = TOK_BAD;
        endcase
        return k;
    endfunction

    assign full     = rec_full;
    assign rec_push = push && !rec_full;
    assign pos_cur  = start_of_blob ? '0 : pos_reg;
    assign pos_next = pos_cur + 32'd4;
    assign plus3    = {1'b0, blob_word} + 33'd3;

    always_comb
    begin
        rec.start     = start_of_blob;
        rec.pos       = pos_cur;
        rec.word      = blob_word;
        rec.next4     = {1'b0, pos_cur} + 33'd4;
        rec.next12    = {2'b00, pos_cur} + 34'd12;
        rec.zero_byte = (blob_word[31:24] == '0) || (blob_word[23:16] == '0) ||
                        (blob_word[15:8] == '0) || (blob_word[7:0] == '0);
        rec.pad_words = plus3[31:2];
        rec.tok       = classify(blob_word);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (rec_push)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

[rtl/dttp_back.sv]
// Back end: header checks, token state machine, depth tracking, events.
// Depends on dttp_pkg; pops the middle queue and pushes the result queue.
`default_nettype none

module dttp_back
    import dttp_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire word_rec_t rec,
    input  wire logic      rec_empty,
    output logic           rec_pop,
    input  wire logic      res_full,
    output logic           res_push,
    output result_t        res
);

    localparam int NEST_W = $clog2(MAX_NEST) + 1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SEEK,
        PH_TOKEN,
        PH_NAME,
        PH_PROPHDR,
        PH_PROPDATA
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [31:0]       sstart_reg;
    logic [31:0]       sstart_next;
    logic [32:0]       send_reg;
    logic [32:0]       send_next;
    logic [NEST_W-1:0] nest_reg;
    logic [NEST_W-1:0] nest_next;
    logic [NEST_W-1:0] nest_inc;
    logic [29:0]       skip_reg;
    logic [29:0]       skip_next;
    logic [31:0]       name_reg;
    logic [31:0]       name_next;
    logic [1:0]        left_reg;
    logic [1:0]        left_next;
    logic              fin_reg;
    logic              fin_next;
    logic              do_token;
    logic              ev_valid;

    assign rec_pop  = !rec_empty && !res_full;
    assign res_push = rec_pop && ev_valid;
    assign nest_inc = (rec.start ? '1 : nest_reg) + NEST_W'(1);

    always_comb
    begin
        phase_next  = rec.start ? PH_HEADER : phase_reg;
        sstart_next = rec.start ? '0 : sstart_reg;
        send_next   = rec.start ? '0 : send_reg;
        nest_next   = rec.start ? '1 : nest_reg;
        skip_next   = rec.start ? '0 : skip_reg;
        name_next   = rec.start ? '0 : name_reg;
        left_next   = rec.start ? '0 : left_reg;
        fin_next    = rec.start ? 1'b0 : fin_reg;
        ev_valid    = 1'b0;
        res         = '0;
        res.kind    = EV_NODE;
        do_token    = (phase_next == PH_TOKEN) ||
                      ((phase_next == PH_SEEK) && (rec.pos == sstart_next));
        if (!fin_next)
        begin
            case (phase_next)
                PH_HEADER:
                begin
                    if (rec.pos == POS_MAGIC && rec.word != BLOB_MAGIC)
                    begin
                        ev_valid = 1'b1;
                        res.kind = EV_BADHDR;
                        fin_next = 1'b1;
                    end
                    else if (rec.pos == POS_OFF_STRUCT)
                    begin
                        sstart_next = rec.word;
                    end
                    else if (rec.pos == POS_LAST_COMP && rec.word > BLOB_VERSION)
                    begin
                        ev_valid = 1'b1;
                        res.kind = EV_BADHDR;
                        fin_next = 1'b1;
                    end
                    else if (rec.pos == POS_SIZE_STRUCT)
                    begin
                        send_next = {1'b0, sstart_next} + {1'b0, rec.word};
                        if (sstart_next[1:0] != 2'b00 || sstart_next < MIN_STRUCT_OFF)
                        begin
                            ev_valid = 1'b1;
                            res.kind = EV_BADHDR;
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SEEK;
                        end
                    end
                end
                PH_NAME:
                begin
                    if (rec.zero_byte)
                    begin
                        ev_valid = 1'b1;
                        if (rec.next4 > send_next)
                        begin
                            res.kind = EV_TRUNC;
                            fin_next = 1'b1;
                        end
                        else if (nest_next == NEST_W'(MAX_NEST - 1))
                        begin
                            res.kind = EV_DEEP;
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            nest_next        = nest_inc;
                            phase_next       = PH_TOKEN;
                            res.kind         = EV_NODE;
                            res.depth        = 5'({{(32 - NEST_W){1'b0}}, nest_inc});
                            res.name_offset  = name_next;
                            res.props_offset = rec.next4[31:0];
                        end
                    end
                end
                PH_PROPHDR:
                begin
                    if (left_next == PROP_HDR_WORDS)
                    begin
                        skip_next = rec.pad_words;
                    end
                    left_next = left_next - 2'd1;
                    if (left_next == 2'd0)
                    begin
                        phase_next = (skip_next == '0) ? PH_TOKEN : PH_PROPDATA;
                    end
                end
                PH_PROPDATA:
                begin
                    skip_next = skip_next - 30'd1;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
                default:
                begin
                end
            endcase
            if (do_token)
            begin
                phase_next = PH_TOKEN;
                if (rec.next4 > send_next)
                begin
                    ev_valid = 1'b1;
                    res.kind = EV_TRUNC;
                    fin_next = 1'b1;
                end
                else
                begin
                    case (rec.tok)
                        TOK_BEGIN:
                        begin
                            name_next  = rec.next4[31:0];
                            phase_next = PH_NAME;
                        end
                        TOK_END_NODE:
                        begin
                            if (nest_next == '1)
                            begin
                                ev_valid = 1'b1;
                                res.kind = EV_UNDER;
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                nest_next = nest_next - NEST_W'(1);
                            end
                        end
                        TOK_PROP:
                        begin
                            if (rec.next12 > {1'b0, send_next})
                            begin
                                ev_valid = 1'b1;
                                res.kind = EV_TRUNC;
                                fin_next = 1'b1;
                            end
                            else
                            begin
                                left_next  = PROP_HDR_WORDS;
                                phase_next = PH_PROPHDR;
                            end
                        end
                        TOK_NOP:
                        begin
                        end
                        TOK_FINISH:
                        begin
                            ev_valid = 1'b1;
                            res.kind = EV_DONE;
                            fin_next = 1'b1;
                        end
                        default:
                        begin
                            ev_valid = 1'b1;
                            res.kind = EV_BADTOK;
                            fin_next = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            sstart_reg <= '0;
            send_reg   <= '0;
            nest_reg   <= '1;
            skip_reg   <= '0;
            name_reg   <= '0;
            left_reg   <= '0;
            fin_reg    <= 1'b0;
        end
        else if (rec_pop)
        begin
            phase_reg  <= phase_next;
            sstart_reg <= sstart_next;
            send_reg   <= send_next;
            nest_reg   <= nest_next;
            skip_reg   <= skip_next;
            name_reg   <= name_next;
            left_reg   <= left_next;
            fin_reg    <= fin_next;
        end
    end

    a_push_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> rec_pop)
        else $error("result pushed without a word transfer");

    a_terminal_event: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.kind != EV_NODE) |=> fin_reg)
        else $error("parser not finished after terminal event");

    a_nest_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nest_reg == '1) || (nest_reg < NEST_W'(MAX_NEST)))
        else $error("nesting level out of range");

    a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PROPDATA) |-> (skip_reg != '0))
        else $error("property data phase with nothing to skip");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for device_tree_token_parser_top: random and hand-built blobs, idle gaps on
// both channels, and an event predictor kept in a small class. Depends on dttp_pkg and the RTL.
`timescale 1ns / 100ps

import dttp_pkg::*;

class blob_event_model;
    typedef enum logic [2:0] {
        WALK_HEADER,
        WALK_SEEK,
        WALK_TOKEN,
        WALK_NAME,
        WALK_PROP_HDR,
        WALK_PROP_DATA
    } walk_t;

    logic [31:0] pos;
    walk_t       phase;
    logic [31:0] struct_start;
    logic [32:0] struct_end;
    int          nest;
    logic [29:0] skip_words;
    logic [31:0] name_start;
    logic [1:0]  hdr_left;
    bit          finished;
    result_t     awaited_events[$];
    int          mismatches;

    function new();
        mismatches = 0;
        restart();
    endfunction

    function void restart();
        pos          = '0;
        phase        = WALK_HEADER;
        struct_start = '0;
        struct_end   = '0;
        nest         = -1;
        skip_words   = '0;
        name_start   = '0;
        hdr_left     = '0;
        finished     = 1'b0;
    endfunction

    function void add_event(ev_kind_t kind, logic [4:0] depth, logic [31:0] name,
                            logic [31:0] props);
        result_t r;
        r.kind         = kind;
        r.depth        = depth;
        r.name_offset  = name;
        r.props_offset = props;
        awaited_events.push_back(r);
    endfunction

    function void abort(ev_kind_t kind);
        finished = 1'b1;
        add_event(kind, '0, '0, '0);
    endfunction

    function void note_word(bit sob, logic [31:0] w);
        logic [32:0] next;
        if (sob)
            restart();
        next = {1'b0, pos} + 33'd4;
        if (!finished)
        begin
            if (phase == WALK_SEEK && pos == struct_start)
                phase = WALK_TOKEN;
            case (phase)
                WALK_HEADER:
                begin
                    if (pos == POS_MAGIC && w != BLOB_MAGIC)
                        abort(EV_BADHDR);
                    else
                    begin
                        if (pos == POS_OFF_STRUCT)
                            struct_start = w;
                        if (pos == POS_LAST_COMP && w > BLOB_VERSION)
                            abort(EV_BADHDR);
                        else if (pos == POS_SIZE_STRUCT)
                        begin
                            struct_end = {1'b0, struct_start} + {1'b0, w};
                            if (struct_start[1:0] != 2'd0 || struct_start < MIN_STRUCT_OFF)
                                abort(EV_BADHDR);
                            else
                                phase = WALK_SEEK;
                        end
                    end
                end
                WALK_TOKEN:
                begin
                    if (next > struct_end)
                        abort(EV_TRUNC);
                    else
                    begin
                        case (w)
                            TOKEN_BEGIN_NODE:
                            begin
                                name_start = next[31:0];
                                phase      = WALK_NAME;
                            end
                            TOKEN_END_NODE:
                            begin
                                if (nest == -1)
                                    abort(EV_UNDER);
                                else
                                    nest--;
                            end
                            TOKEN_PROP:
                            begin
                                if (({1'b0, next} + 34'd8) > {1'b0, struct_end})
                                    abort(EV_TRUNC);
                                else
                                begin
                                    hdr_left = PROP_HDR_WORDS;
                                    phase    = WALK_PROP_HDR;
                                end
                            end
                            TOKEN_NOP:
                            begin
                            end
                            TOKEN_END:
                            begin
                                finished = 1'b1;
                                add_event(EV_DONE, '0, '0, '0);
                            end
                            default:
                                abort(EV_BADTOK);
                        endcase
                    end
                end
                WALK_NAME:
                begin
                    if (w[31:24] == 8'd0 || w[23:16] == 8'd0 || w[15:8] == 8'd0
                        || w[7:0] == 8'd0)
                    begin
                        if (next > struct_end)
                            abort(EV_TRUNC);
                        else if (nest + 1 >= MAX_NEST_DEFAULT)
                            abort(EV_DEEP);
                        else
                        begin
                            nest++;
                            phase = WALK_TOKEN;
                            add_event(EV_NODE, 5'(nest), name_start, next[31:0]);
                        end
                    end
                end
                WALK_PROP_HDR:
                begin
                    if (hdr_left == PROP_HDR_WORDS)
                        skip_words = 30'(({1'b0, w} + 33'd3) >> 2);
                    hdr_left = hdr_left - 2'd1;
                    if (hdr_left == 2'd0)
                        phase = (skip_words == 30'd0) ? WALK_TOKEN : WALK_PROP_DATA;
                end
                WALK_PROP_DATA:
                begin
                    skip_words = skip_words - 30'd1;
                    if (skip_words == 30'd0)
                        phase = WALK_TOKEN;
                end
                default:
                begin
                end
            endcase
        end
        pos = pos + 32'd4;
    endfunction

    function void check_event(logic [2:0] kind, logic [4:0] depth, logic [31:0] name,
                              logic [31:0] props);
        result_t r;
        if (awaited_events.size() == 0)
        begin
            $error("event_kind %0d transferred with no event pending", kind);
            mismatches++;
            return;
        end
        r = awaited_events.pop_front();
        if (kind !== r.kind)
        begin
            $error("event_kind expected %0d actual %0d", r.kind, kind);
            mismatches++;
        end
        if (depth !== r.depth)
        begin
            $error("node_depth expected %0d actual %0d", r.depth, depth);
            mismatches++;
        end
        if (name !== r.name_offset)
        begin
            $error("name_offset expected 0x%h actual 0x%h", r.name_offset, name);
            mismatches++;
        end
        if (props !== r.props_offset)
        begin
            $error("props_offset expected 0x%h actual 0x%h", r.props_offset, props);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        start_of_blob;
    logic [31:0] blob_word;
    logic        empty;
    logic        pop;
    logic [2:0]  event_kind;
    logic [4:0]  node_depth;
    logic [31:0] name_offset;
    logic [31:0] props_offset;

    blob_event_model blob_events;
    logic [31:0]     blob_q[$];
    logic [31:0]     tok_q[$];
    bit              blob_noise;
    bit              tx_steady;
    bit              rx_steady;
    int              words_sent;
    int              results_seen;

    device_tree_token_parser_top #(
        .MAX_NEST(MAX_NEST_DEFAULT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .start_of_blob(start_of_blob),
        .blob_word(blob_word),
        .empty(empty),
        .pop(pop),
        .event_kind(event_kind),
        .node_depth(node_depth),
        .name_offset(name_offset),
        .props_offset(props_offset)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap(bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] nonzero_word();
        return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
    endfunction

    function automatic void add_name();
        int          n;
        int          k;
        logic [31:0] w;
        n = $urandom_range(1, 3);
        repeat (n - 1) tok_q.push_back(nonzero_word());
        w = ($urandom_range(0, 7) == 0) ? 32'd0 : nonzero_word();
        k = $urandom_range(0, 3);
        w[8 * k +: 8] = 8'd0;
        tok_q.push_back(w);
    endfunction

    function automatic void add_prop();
        int          r;
        logic [31:0] len;
        r = $urandom_range(0, 9);
        if (r < 7)
            len = $urandom_range(0, 12);
        else if (r < 9)
            len = $urandom_range(13, 48);
        else
            len = 32'hffff_fffd + $urandom_range(0, 2);
        tok_q.push_back(TOKEN_PROP);
        tok_q.push_back(len);
        tok_q.push_back($urandom);
        if (r < 9)
            repeat ((len + 3) / 4) tok_q.push_back($urandom);
    endfunction

    function automatic void build_tokens(bit deep);
        int open;
        int steps;
        int r;
        tok_q.delete();
        if (deep)
        begin
            open = $urandom_range(30, 34);
            repeat (open)
            begin
                tok_q.push_back(TOKEN_BEGIN_NODE);
                add_name();
            end
        end
        else
        begin
            tok_q.push_back(TOKEN_BEGIN_NODE);
            add_name();
            open  = 1;
            steps = $urandom_range(1, 12);
            repeat (steps)
            begin
                r = $urandom_range(0, 9);
                if (r < 3 && open < 5)
                begin
                    tok_q.push_back(TOKEN_BEGIN_NODE);
                    add_name();
                    open++;
                end
                else if (r < 5 && open > 1)
                begin
                    tok_q.push_back(TOKEN_END_NODE);
                    open--;
                end
                else if (r < 8)
                    add_prop();
                else
                    tok_q.push_back(TOKEN_NOP);
            end
        end
        repeat (open) tok_q.push_back(TOKEN_END_NODE);
        tok_q.push_back(TOKEN_END);
    endfunction

    function automatic void put_header(logic [31:0] magic, logic [31:0] off,
                                       logic [31:0] comp, logic [31:0] size);
        blob_q.delete();
        blob_q.push_back(magic);
        blob_q.push_back($urandom);
        blob_q.push_back(off);
        repeat (3) blob_q.push_back($urandom);
        blob_q.push_back(comp);
        repeat (2) blob_q.push_back($urandom);
        blob_q.push_back(size);
    endfunction

    function automatic void build_blob();
        int          flaw;
        int          need;
        int          idx;
        int          cut;
        logic [31:0] off;
        logic [31:0] magic;
        logic [31:0] comp;
        logic [31:0] size;
        logic [31:0] bad;
        flaw       = $urandom_range(0, 19);
        blob_noise = (flaw == 9);
        if (blob_noise)
        begin
            blob_q.delete();
            repeat ($urandom_range(1, 6))
                blob_q.push_back(($urandom_range(0, 2) == 0) ? BLOB_MAGIC : $urandom);
            return;
        end
        build_tokens($urandom_range(0, 11) == 0);
        if (flaw == 4)
        begin
            bad = $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : $urandom;
            if (bad inside {TOKEN_BEGIN_NODE, TOKEN_END_NODE, TOKEN_PROP, TOKEN_NOP, TOKEN_END})
                bad = 32'd0;
            idx = $urandom_range(0, tok_q.size() - 1);
            tok_q.insert(idx, bad);
        end
        if (flaw == 5)
            tok_q.insert(tok_q.size() - 1, TOKEN_END_NODE);
        need = 4 * tok_q.size();
        size = need;
        if (flaw == 6)
            size = need - $urandom_range(1, (need > 40) ? 40 : need);
        else if (flaw == 8)
            size = need + ($urandom >> 1);
        magic = (flaw == 0) ? (BLOB_MAGIC ^ (32'd1 << $urandom_range(0, 31))) : BLOB_MAGIC;
        if (flaw == 1)
            comp = $urandom_range(0, 1) ? 32'd18 : 32'hffff_ffff;
        else
            comp = $urandom_range(0, 17);
        if (flaw == 2)
            off = MIN_STRUCT_OFF + 4 * $urandom_range(0, 3) + $urandom_range(1, 3);
        else if (flaw == 3)
            off = 4 * $urandom_range(0, 9);
        else
            off = MIN_STRUCT_OFF + 4 * $urandom_range(0, 3);
        put_header(magic, off, comp, size);
        while (blob_q.size() * 4 < off)
            blob_q.push_back($urandom);
        foreach (tok_q[i])
            blob_q.push_back(tok_q[i]);
        if (flaw == 7)
        begin
            cut = $urandom_range(1, blob_q.size() - 1);
            while (blob_q.size() > cut)
                void'(blob_q.pop_back());
        end
    endfunction

    task automatic send_word(bit sob, logic [31:0] w);
        int gap;
        push          <= 1'b1;
        start_of_blob <= sob;
        blob_word     <= w;
        do @(posedge clk); while (full);
        blob_events.note_word(sob, w);
        words_sent++;
        gap = pick_gap(tx_steady);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_blob();
        tx_steady = ($urandom_range(0, 4) == 0);
        foreach (blob_q[i])
            send_word(blob_noise ? ($urandom_range(0, 3) == 0) : (i == 0), blob_q[i]);
    endtask

    initial
    begin
        int  gap;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (results_seen == 20 && !held)
            begin
                // hold the result side so the parser backs up into full
                pop <= 1'b0;
                repeat (300) @(posedge clk);
                held = 1'b1;
            end
            gap = pick_gap(rx_steady);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            blob_events.check_event(event_kind, node_depth, name_offset, props_offset);
            results_seen++;
            if (results_seen % 32 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        push          <= 1'b0;
        start_of_blob <= 1'b0;
        blob_word     <= '0;
        pop           <= 1'b0;
        rst_n         <= 1'b0;
        blob_events = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first transfer after reset without a start flag, then ignored after the error
        send_word(1'b0, 32'hffff_ffff);
        send_word(1'b0, 32'h0000_0000);

        // smallest valid tree: root with an empty name
        put_header(BLOB_MAGIC, MIN_STRUCT_OFF, BLOB_VERSION, 32'd16);
        blob_q.push_back(TOKEN_BEGIN_NODE);
        blob_q.push_back(32'd0);
        blob_q.push_back(TOKEN_END_NODE);
        blob_q.push_back(TOKEN_END);
        send_blob();

        // last compatible version one past the limit
        put_header(BLOB_MAGIC, MIN_STRUCT_OFF, BLOB_VERSION + 32'd1, 32'd0);
        while (blob_q.size() > 7)
            void'(blob_q.pop_back());
        send_blob();

        while (words_sent < 750)
        begin
            build_blob();
            send_blob();
        end
        push <= 1'b0;

        while (blob_events.awaited_events.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (blob_events.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[device_tree_token_parser_top.f]
rtl/dttp_pkg.sv
rtl/dttp_fifo.sv
rtl/dttp_front.sv
rtl/dttp_back.sv
rtl/device_tree_token_parser_top.sv
bench/testbench.sv
